### hdl/salct_pkg.sv
package salct_pkg;

    localparam int DEF_SETS       = 256;
    localparam int DEF_WAYS       = 8;
    localparam int DEF_ADDR_WIDTH = 64;

    localparam int FUNC_W     = 2;
    localparam int ADDRESS_W  = 64;
    localparam int OUTCOME_W  = 2;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SET_BITS_W = 4;
    localparam int BLK_BITS_W = 6;
    localparam int WAYS_W     = 4;

    // set index before the wrap to the set count
    localparam int RAW_W     = 15;
    localparam int MOD_SHIFT = 31;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FETCH  = 2'd3;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_SKIP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
    localparam logic [BLK_BITS_W-1:0] BLK_BITS_RST = 6'd4;
    localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [ADDRESS_W-1:0] address;
    } access_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic                 second_hit;
        logic [CNT_W-1:0]     hit_count;
        logic [CNT_W-1:0]     miss_count;
        logic [CNT_W-1:0]     eviction_count;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt, input logic en);
        logic [CNT_W-1:0] res;
        res = cnt;
        if (en && (cnt != '1))
        begin
            res = cnt + CNT_W'(1);
        end
        return res;
    endfunction

endpackage

### hdl/set_assoc_lru_cache_tracker_core.sv
// set-associative cache tracker with lru replacement
// channels: access (valid/stall) takes one request, a func code and a byte
// address; result (valid/stall) returns one item per request with the
// outcome, the second-lookup flag of a modify and the saturating hit, miss
// and eviction totals; cfg (valid/ready) writes set_bits, block_bits and
// ways_used by index, always ready, meant to be used while idle
// requests go one at a time through the steps accept, reciprocal multiply for the
// set wrap, tag row read from the single-port set memory, and lookup with row
// write-back; the result register loads when the lookup fires, and access_stall
// stays high until then, so a new request is taken only after that lookup
// a finished result waits in the output register while the next request is
// taken; if the receiver holds stall, the lookup of the following request
// waits until the output register frees
// reset: after rst_n releases, a clearing pass writes every set row in turn,
// with access_stall high; cfg writes are taken meanwhile
module set_assoc_lru_cache_tracker_core
    import salct_pkg::*;
#(
    parameter int SETS       = DEF_SETS,
    parameter int WAYS       = DEF_WAYS,
    parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  access_valid,
    output logic                  access_stall,
    input  access_t               access,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W   = $clog2(WAYS + 1);
    localparam int ENT_W  = 1 + RANK_W + ADDR_WIDTH;
    localparam int ROW_W  = WAYS * ENT_W;
    localparam int SH_W   = 7;
    localparam logic [31:0]       RECIP    = 32'((64'(1) << MOD_SHIFT) / SETS);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
    localparam logic [SET_W-1:0]  SET_LAST = SET_W'(SETS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LU   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SET_W-1:0]      clr_cnt_reg;
    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [BLK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_W-1:0]     ways_used_reg;
    logic [CNT_W-1:0]      hits_reg, misses_reg, evicts_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [FUNC_W-1:0]     func_reg;
    logic [RAW_W-1:0]      raw_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [RAW_W-1:0]      q_reg;
    logic [SET_W-1:0]      set_reg;

    logic [ROW_W-1:0]      mem [SETS];
    logic [ROW_W-1:0]      rdata_reg;
    logic                  mem_we;
    logic [SET_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    logic                  acc_fire;
    logic                  lu_fire;
    logic [ADDR_WIDTH-1:0] addr_w;
    logic [RAW_W-1:0]      set_mask;
    logic [RAW_W-1:0]      raw_next;
    logic [SH_W-1:0]       tag_shift;
    logic [ADDR_WIDTH-1:0] tag_next;
    logic [RAW_W+31:0]     prod;
    logic [31:0]           qs;
    logic [31:0]           r0;
    logic [31:0]           r1;
    logic [SET_W-1:0]      set_next;

    logic [NW_W-1:0]       n_eff;
    logic [WAYS-1:0]       vld;
    logic [RANK_W-1:0]     rnk [WAYS];
    logic [WAYS-1:0]       in_use;
    logic [WAYS-1:0]       hit_vec;
    logic [WAYS-1:0]       empty_vec;
    logic [WAYS-1:0]       lru_vec;
    logic [WAYS-1:0]       sel_vec;
    logic [WAYS-1:0]       pick;
    logic                  any_hit;
    logic                  any_empty;
    logic                  was_valid;
    logic [RANK_W-1:0]     old_rank;
    logic [ROW_W-1:0]      row_new;
    logic                  skip;
    logic [CNT_W-1:0]      hits_next, misses_next, evicts_next;
    logic [OUTCOME_W-1:0]  outcome;

    assign acc_fire     = access_valid && !access_stall;
    assign access_stall = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign lu_fire      = (state_reg == S_LU) && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // address split
    always_comb
    begin
        addr_w    = access.address[ADDR_WIDTH-1:0];
        set_mask  = RAW_W'((17'(1) << set_bits_reg) - 17'(1));
        raw_next  = RAW_W'(addr_w >> block_bits_reg) & set_mask;
        tag_shift = SH_W'(set_bits_reg) + SH_W'(block_bits_reg);
        if (32'(tag_shift) >= ADDR_WIDTH)
        begin
            tag_next = '0;
        end
        else
        begin
            tag_next = addr_w >> tag_shift;
        end
    end

    // set index wrap by reciprocal
    always_comb
    begin
        prod = (RAW_W + 32)'(raw_reg) * (RAW_W + 32)'(RECIP);
        qs   = 32'(q_reg) * 32'(SETS);
        r0   = 32'(raw_reg) - qs;
        r1   = (r0 >= 32'(SETS)) ? (r0 - 32'(SETS)) : r0;
        set_next = SET_W'(r1);
    end

    // lookup and lru update
    always_comb
    begin
        if (ways_used_reg == '0)
        begin
            n_eff = NW_W'(1);
        end
        else if (32'(ways_used_reg) > WAYS)
        begin
            n_eff = NW_W'(WAYS);
        end
        else
        begin
            n_eff = NW_W'(ways_used_reg);
        end
        for (int w = 0; w < WAYS; w++)
        begin
            vld[w]       = rdata_reg[w*ENT_W + ENT_W - 1];
            rnk[w]       = rdata_reg[w*ENT_W + ADDR_WIDTH +: RANK_W];
            in_use[w]    = (32'(w) < 32'(n_eff));
            hit_vec[w]   = in_use[w] && vld[w]
                           && (rdata_reg[w*ENT_W +: ADDR_WIDTH] == tag_reg);
            empty_vec[w] = in_use[w] && !vld[w];
        end
        for (int w = 0; w < WAYS; w++)
        begin
            lru_vec[w] = in_use[w];
            for (int v = 0; v < WAYS; v++)
            begin
                if (in_use[v] && (v < w) && !(rnk[v] < rnk[w]))
                begin
                    lru_vec[w] = 1'b0;
                end
                if (in_use[v] && (v > w) && (rnk[v] > rnk[w]))
                begin
                    lru_vec[w] = 1'b0;
                end
            end
        end
        any_hit   = |hit_vec;
        any_empty = |empty_vec;
        if (any_hit)
        begin
            sel_vec = hit_vec;
        end
        else if (any_empty)
        begin
            sel_vec = empty_vec;
        end
        else
        begin
            sel_vec = lru_vec;
        end
        pick      = sel_vec & (~sel_vec + WAYS'(1));
        was_valid = |(pick & vld);
        old_rank  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (pick[w])
            begin
                old_rank = old_rank | rnk[w];
            end
        end
        row_new = rdata_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (pick[w])
            begin
                row_new[w*ENT_W +: ENT_W] = {1'b1, RANK_W'(0), tag_reg};
            end
            else if (vld[w] && (!was_valid || (rnk[w] < old_rank)) && (rnk[w] < RANK_MAX))
            begin
                row_new[w*ENT_W + ADDR_WIDTH +: RANK_W] = rnk[w] + RANK_W'(1);
            end
        end

        skip        = (func_reg == FUNC_FETCH);
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        outcome     = OUT_SKIP;
        if (!skip)
        begin
            hits_next   = sat_inc(sat_inc(hits_reg, any_hit), func_reg == FUNC_MODIFY);
            misses_next = sat_inc(misses_reg, !any_hit);
            evicts_next = sat_inc(evicts_reg, !any_hit && !any_empty);
            if (any_hit)
            begin
                outcome = OUT_HIT;
            end
            else if (any_empty)
            begin
                outcome = OUT_FILL;
            end
            else
            begin
                outcome = OUT_EVICT;
            end
        end
    end

    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = lu_fire && !skip;
            mem_waddr = set_reg;
            mem_wdata = row_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_RD)
        begin
            rdata_reg <= mem[set_next];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == SET_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc_fire)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_LU;
            end
            S_LU:
            begin
                if (lu_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLK_BITS_RST;
            ways_used_reg  <= WAYS_RST;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[SET_BITS_W-1:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BLK_BITS_W-1:0];
                    CFG_WAYS_USED:  ways_used_reg  <= cfg_data[WAYS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (lu_fire)
            begin
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evicts_reg    <= evicts_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire)
        begin
            func_reg <= access.func;
            raw_reg  <= raw_next;
            tag_reg  <= tag_next;
        end
        if (state_reg == S_MUL)
        begin
            q_reg <= prod[MOD_SHIFT +: RAW_W];
        end
        if (state_reg == S_RD)
        begin
            set_reg <= set_next;
        end
        if (lu_fire)
        begin
            out_reg.outcome        <= outcome;
            out_reg.second_hit     <= (func_reg == FUNC_MODIFY);
            out_reg.hit_count      <= hits_next;
            out_reg.miss_count     <= misses_next;
            out_reg.eviction_count <= evicts_next;
        end
    end

endmodule

### tb/set_assoc_lru_cache_tracker_core_test.sv
`timescale 1ns / 100ps

module set_assoc_lru_cache_tracker_core_test;
    import salct_pkg::*;

    localparam int NUM_SETS        = DEF_SETS;
    localparam int NUM_WAYS        = DEF_WAYS;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int NUM_PHASES      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class cache_scoreboard;
        logic                  present [NUM_SETS][NUM_WAYS];
        logic [63:0]           tags    [NUM_SETS][NUM_WAYS];
        logic [2:0]            rank    [NUM_SETS][NUM_WAYS];
        logic [CNT_W-1:0]      hits;
        logic [CNT_W-1:0]      misses;
        logic [CNT_W-1:0]      evictions;
        logic [SET_BITS_W-1:0] set_bits;
        logic [BLK_BITS_W-1:0] block_bits;
        logic [WAYS_W-1:0]     ways_used;
        result_t               expected_q[$];
        int                    errors;
        int                    seen[4];

        function new();
            for (int s = 0; s < NUM_SETS; s++)
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    present[s][w] = 1'b0;
                    tags[s][w]    = '0;
                    rank[s][w]    = '0;
                end
            end
            hits       = '0;
            misses     = '0;
            evictions  = '0;
            set_bits   = SET_BITS_RST;
            block_bits = BLK_BITS_RST;
            ways_used  = WAYS_RST;
            errors     = 0;
            for (int i = 0; i < 4; i++)
            begin
                seen[i] = 0;
            end
        endfunction

        function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_BITS:   set_bits   = data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits = data[BLK_BITS_W-1:0];
                CFG_WAYS_USED:  ways_used  = data[WAYS_W-1:0];
                default:        ;
            endcase
        endfunction

        function logic [CNT_W-1:0] incr_sat(logic [CNT_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // make way w the most recent line of set s
        function void promote(int s, int w);
            logic       was;
            logic [2:0] old;
            was = present[s][w];
            old = rank[s][w];
            for (int v = 0; v < NUM_WAYS; v++)
            begin
                if (v != w && present[s][v])
                begin
                    if ((!was || rank[s][v] < old) && rank[s][v] < NUM_WAYS - 1)
                    begin
                        rank[s][v] = rank[s][v] + 1'b1;
                    end
                end
            end
            rank[s][w] = '0;
        endfunction

        function logic [OUTCOME_W-1:0] probe(int s, logic [63:0] t, int n);
            int pick;
            bit empty;
            pick  = 0;
            empty = 1'b0;
            for (int w = 0; w < n; w++)
            begin
                if (present[s][w] && tags[s][w] == t)
                begin
                    promote(s, w);
                    hits = incr_sat(hits);
                    return OUT_HIT;
                end
            end
            misses = incr_sat(misses);
            for (int w = 0; w < n; w++)
            begin
                if (!present[s][w] && !empty)
                begin
                    pick  = w;
                    empty = 1'b1;
                end
            end
            if (!empty)
            begin
                for (int w = 1; w < n; w++)
                begin
                    if (rank[s][w] > rank[s][pick])
                    begin
                        pick = w;
                    end
                end
            end
            promote(s, pick);
            present[s][pick] = 1'b1;
            tags[s][pick]    = t;
            if (empty)
            begin
                return OUT_FILL;
            end
            evictions = incr_sat(evictions);
            return OUT_EVICT;
        endfunction

        function void note_access(access_t a);
            result_t     r;
            int          n;
            int          shift;
            int          s;
            logic [63:0] idx;
            logic [63:0] t;
            n = int'(ways_used);
            if (n == 0)
            begin
                n = 1;
            end
            if (n > NUM_WAYS)
            begin
                n = NUM_WAYS;
            end
            r = '0;
            r.outcome = OUT_SKIP;
            if (a.func != FUNC_FETCH)
            begin
                idx   = (a.address >> block_bits) & ((64'd1 << set_bits) - 64'd1);
                s     = int'(idx % NUM_SETS);
                shift = int'(set_bits) + int'(block_bits);
                t     = (shift >= 64) ? 64'd0 : (a.address >> shift);
                r.outcome = probe(s, t, n);
                if (a.func == FUNC_MODIFY)
                begin
                    r.second_hit = (probe(s, t, n) == OUT_HIT);
                end
            end
            r.hit_count      = hits;
            r.miss_count     = misses;
            r.eviction_count = evictions;
            seen[r.outcome]++;
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result with no request waiting, outcome %0d", got.outcome);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.outcome !== want.outcome)
            begin
                $error("outcome expected %0d actual %0d", want.outcome, got.outcome);
                errors++;
            end
            if (got.second_hit !== want.second_hit)
            begin
                $error("second_hit expected %0d actual %0d", want.second_hit, got.second_hit);
                errors++;
            end
            if (got.hit_count !== want.hit_count)
            begin
                $error("hit_count expected %0d actual %0d", want.hit_count, got.hit_count);
                errors++;
            end
            if (got.miss_count !== want.miss_count)
            begin
                $error("miss_count expected %0d actual %0d", want.miss_count, got.miss_count);
                errors++;
            end
            if (got.eviction_count !== want.eviction_count)
            begin
                $error("eviction_count expected %0d actual %0d",
                       want.eviction_count, got.eviction_count);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  access_valid = 1'b0;
    logic                  access_stall;
    access_t               access_req   = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result_item;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic hold_req = 1'b0;
    logic holding  = 1'b0;
    logic calm     = 1'b0;

    cache_scoreboard sb;
    int requests   = 0;
    int cfg_writes = 0;
    int quiet      = 0;
    int cur_sb     = 4;
    int cur_bb     = 4;
    int cur_ways   = 1;

    int ph_set [NUM_PHASES] = '{0, 15, 8, 3, 2, -1};
    int ph_blk [NUM_PHASES] = '{0, 63, 56, 5, 6, -1};
    int ph_way [NUM_PHASES] = '{1, 15, 8, 4, 0, -1};

    set_assoc_lru_cache_tracker_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .access       (access_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            sb.configure(cfg_index, cfg_data);
            cfg_writes++;
        end
        if (rst_n && access_valid && !access_stall)
        begin
            sb.note_access(access_req);
            requests++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result_item);
        end
        if (rst_n && ((cfg_valid && cfg_ready) || (access_valid && !access_stall) ||
                      (result_valid && !result_stall)))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("set_assoc_lru_cache_tracker_core_test: FAIL");
            $finish;
        end
    end

    // receiver side
    initial
    begin
        int len;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req     <= 1'b0;
                holding      <= 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding      <= 1'b0;
                result_stall <= 1'b0;
            end
            else if (calm)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
                result_stall <= ($urandom_range(0, 2) == 0);
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || holding || r < 65)
        begin
            return 0;
        end
        return (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return FUNC_LOAD;
        end
        if (r < 6)
        begin
            return FUNC_STORE;
        end
        if (r < 9)
        begin
            return FUNC_MODIFY;
        end
        return FUNC_FETCH;
    endfunction

    // mostly a few tags in a few sets so lines get reused and evicted
    function automatic logic [63:0] make_address(int sbits, int bbits, int nways);
        logic [63:0] a;
        logic [63:0] off;
        logic [63:0] setf;
        logic [63:0] tagv;
        int          shift;
        off = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 15)
        begin
            return off;
        end
        off   = off & ((64'd1 << bbits) - 64'd1);
        setf  = 64'($urandom_range(0, 3)) & ((64'd1 << sbits) - 64'd1);
        tagv  = 64'($urandom_range(0, nways + 2));
        shift = sbits + bbits;
        a     = off | (setf << bbits);
        if (shift < 64)
        begin
            a = a | (tagv << shift);
        end
        return a;
    endfunction

    task automatic send_access(input access_t a);
        access_valid <= 1'b1;
        access_req   <= a;
        @(posedge clk);
        while (access_stall) @(posedge clk);
    endtask

    task automatic issue(input logic [FUNC_W-1:0] f, input logic [63:0] addr);
        access_t a;
        int      gap;
        a.func    = f;
        a.address = addr;
        send_access(a);
        gap = pick_gap();
        if (gap > 0)
        begin
            access_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one edge first so the last accepted request is already noted
    task automatic settle();
        access_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input int s, input int b, input int w);
        settle();
        write_reg(CFG_SET_BITS, {4'($urandom_range(0, 15)), 4'(s)});
        write_reg(CFG_BLOCK_BITS, {2'($urandom_range(0, 3)), 6'(b)});
        write_reg(CFG_WAYS_USED, {4'($urandom_range(0, 15)), 4'(w)});
        cur_sb   = s;
        cur_bb   = b;
        cur_ways = (w == 0) ? 1 : ((w > NUM_WAYS) ? NUM_WAYS : w);
    endtask

    initial
    begin
        int s;
        int b;
        int w;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one way, 16 sets of 16-byte blocks
        issue(FUNC_LOAD, 64'h0);
        issue(FUNC_LOAD, 64'h8);
        issue(FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(FUNC_FETCH, 64'h0);
        issue(FUNC_MODIFY, 64'h100);
        issue(FUNC_LOAD, 64'h0);

        // out of range index is ignored
        settle();
        write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));

        // two sets, two ways, lru order
        apply_config(1, 0, 2);
        issue(FUNC_LOAD, 64'h0);
        issue(FUNC_LOAD, 64'h2);
        issue(FUNC_LOAD, 64'h0);
        issue(FUNC_LOAD, 64'h4);
        issue(FUNC_LOAD, 64'h2);
        issue(FUNC_MODIFY, 64'h1);
        issue(FUNC_STORE, 64'h4);

        // tag shift past the address, set bits past the set count, ways zero
        apply_config(15, 63, 0);
        issue(FUNC_LOAD, 64'h0);
        issue(FUNC_LOAD, 64'h8000_0000_0000_0000);
        issue(FUNC_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
        issue(FUNC_MODIFY, 64'h8000_0000_0000_0005);

        // ways above the store size, fill a whole set then evict
        apply_config(8, 0, 15);
        for (int k = 0; k <= NUM_WAYS; k++)
        begin
            issue(FUNC_LOAD, 64'(k) << 8);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            s = (ph_set[p] < 0) ? $urandom_range(0, 15) : ph_set[p];
            b = (ph_blk[p] < 0) ? $urandom_range(0, 63) : ph_blk[p];
            w = (ph_way[p] < 0) ? $urandom_range(0, 15) : ph_way[p];
            apply_config(s, b, w);
            calm <= (p == 4);
            if (p == 3)
            begin
                hold_req <= 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                issue(pick_func(), make_address(cur_sb, cur_bb, cur_ways));
            end
        end

        settle();
        $display("covered %0d requests: %0d hits, %0d fills, %0d evictions, %0d skipped",
                 requests, sb.seen[OUT_HIT], sb.seen[OUT_FILL], sb.seen[OUT_EVICT],
                 sb.seen[OUT_SKIP]);
        $display("%0d register writes over %0d settings, one long receiver hold",
                 cfg_writes, NUM_PHASES + 4);
        if (sb.errors == 0)
        begin
            $display("set_assoc_lru_cache_tracker_core_test: PASS");
        end
        else
        begin
            $display("set_assoc_lru_cache_tracker_core_test: FAIL");
        end
        $finish;
    end

endmodule
